### src/cras_pkg.sv
// Shared types and codes for the 6502 read-addressing bus sequencer.
// No dependencies; used by cras_step and the top level.
`timescale 1ns / 1ps
`default_nettype none

package cras_pkg;

    typedef enum logic [1:0] {
        KIND_READ = 2'd0,
        KIND_IDLE = 2'd1,
        KIND_DONE = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        AM_IMM  = 4'd0,
        AM_ABS  = 4'd1,
        AM_ZP   = 4'd2,
        AM_ZPX  = 4'd3,
        AM_ZPY  = 4'd4,
        AM_ABSX = 4'd5,
        AM_ABSY = 4'd6,
        AM_INDX = 4'd7,
        AM_INDY = 4'd8
    } t_amode;

    localparam logic       ITEM_START = 1'b0;
    localparam logic       ITEM_DATA  = 1'b1;
    localparam logic [3:0] AM_LAST    = 4'd8;

    // step within an addressing sequence
    localparam logic [2:0] PH_0 = 3'd0;
    localparam logic [2:0] PH_1 = 3'd1;
    localparam logic [2:0] PH_2 = 3'd2;
    localparam logic [2:0] PH_3 = 3'd3;
    localparam logic [2:0] PH_4 = 3'd4;

    typedef struct packed {
        logic        mode;
        logic [3:0]  addressing;
        logic [15:0] pc_in;
        logic [7:0]  index_x;
        logic [7:0]  index_y;
        logic [7:0]  read_data;
    } t_in;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] address;
        logic [7:0]  operand;
        logic [15:0] next_pc;
        logic        last;
    } t_out;

    typedef struct packed {
        logic        busy;
        logic [2:0]  phase;
        t_amode      mode_held;
        logic [15:0] pc_held;
        logic [7:0]  x_held;
        logic [7:0]  y_held;
        logic [8:0]  low_sum;
        logic [7:0]  high_byte;
    } t_state;

endpackage

`default_nettype wire

### src/cras_step.sv
// Next-state and result logic for one transfer of the sequencer.
// Purely combinational; depends on cras_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cras_step (
    input  var cras_pkg::t_state i_state,
    input  var cras_pkg::t_in    i_item,
    output cras_pkg::t_state     o_state,
    output cras_pkg::t_out       o_res0,
    output cras_pkg::t_out       o_res1,
    output logic [1:0]           o_nres
);

    logic [7:0] d;
    logic [7:0] idx;
    logic [8:0] sum;
    logic [7:0] zp_sum;
    logic [7:0] ptr;
    logic [7:0] high_inc;

    assign d        = i_item.read_data;
    assign idx      = ((i_state.mode_held == cras_pkg::AM_ABSX) ||
                       (i_state.mode_held == cras_pkg::AM_ZPX) ||
                       (i_state.mode_held == cras_pkg::AM_INDX)) ?
                      i_state.x_held : i_state.y_held;
    assign sum      = {1'b0, i_state.low_sum[7:0]} + {1'b0, idx};
    assign zp_sum   = d + idx;
    assign ptr      = i_state.low_sum[7:0] + 8'd1;
    assign high_inc = i_state.high_byte + 8'd1;

    always_comb begin
        o_state        = i_state;
        o_res0         = '0;
        o_res0.kind    = cras_pkg::KIND_READ;
        o_res0.next_pc = i_state.pc_held;
        o_res1         = o_res0;
        o_nres         = 2'd0;

        if (i_item.mode == cras_pkg::ITEM_START) begin
            o_state.mode_held = (i_item.addressing > cras_pkg::AM_LAST) ?
                                cras_pkg::AM_IMM : cras_pkg::t_amode'(i_item.addressing);
            o_state.pc_held   = i_item.pc_in + 16'd1;
            o_state.x_held    = i_item.index_x;
            o_state.y_held    = i_item.index_y;
            o_state.low_sum   = '0;
            o_state.high_byte = '0;
            o_state.busy      = 1'b1;
            o_state.phase     = cras_pkg::PH_0;
            o_res0.address    = i_item.pc_in;
            o_res0.next_pc    = i_item.pc_in;
            o_nres            = 2'd1;
        end else if (i_state.busy) begin
            o_nres = 2'd1;
            // finish by default; the arms below override for in-flight steps
            o_state.busy   = 1'b0;
            o_state.phase  = cras_pkg::PH_0;
            o_res0.kind    = cras_pkg::KIND_DONE;
            o_res0.operand = d;
            o_res0.last    = 1'b1;
            unique case (i_state.mode_held)
                cras_pkg::AM_ABS, cras_pkg::AM_ABSX, cras_pkg::AM_ABSY: begin
                    if (i_state.phase == cras_pkg::PH_0) begin
                        o_state         = i_state;
                        o_state.low_sum = {1'b0, d};
                        o_state.phase   = cras_pkg::PH_1;
                        o_state.pc_held = i_state.pc_held + 16'd1;
                        o_res0          = o_res1;
                        o_res0.address  = i_state.pc_held;
                    end else if (i_state.phase == cras_pkg::PH_1) begin
                        o_state           = i_state;
                        o_state.high_byte = d;
                        o_state.phase     = cras_pkg::PH_2;
                        o_res0            = o_res1;
                        if (i_state.mode_held == cras_pkg::AM_ABS) begin
                            o_res0.address = {d, i_state.low_sum[7:0]};
                        end else begin
                            o_state.low_sum = sum;
                            o_res0.address  = {d, sum[7:0]};
                        end
                    end else if (i_state.phase == cras_pkg::PH_2 &&
                                 i_state.mode_held != cras_pkg::AM_ABS &&
                                 i_state.low_sum[8]) begin
                        o_state        = i_state;
                        o_state.phase  = cras_pkg::PH_3;
                        o_res0         = o_res1;
                        o_res0.address = {high_inc, i_state.low_sum[7:0]};
                    end
                end
                cras_pkg::AM_ZP: begin
                    if (i_state.phase == cras_pkg::PH_0) begin
                        o_state         = i_state;
                        o_state.low_sum = {1'b0, d};
                        o_state.phase   = cras_pkg::PH_1;
                        o_res0          = o_res1;
                        o_res0.address  = {8'd0, d};
                    end
                end
                cras_pkg::AM_ZPX, cras_pkg::AM_ZPY, cras_pkg::AM_INDX: begin
                    if (i_state.phase == cras_pkg::PH_0) begin
                        // internal idle cycle, then the wrapped zero page address
                        o_state         = i_state;
                        o_state.low_sum = {1'b0, zp_sum};
                        o_state.phase   = cras_pkg::PH_1;
                        o_res0          = o_res1;
                        o_res0.kind     = cras_pkg::KIND_IDLE;
                        o_res1.address  = {8'd0, zp_sum};
                        o_nres          = 2'd2;
                    end else if (i_state.mode_held == cras_pkg::AM_INDX &&
                                 i_state.phase == cras_pkg::PH_1) begin
                        o_state         = i_state;
                        o_state.low_sum = {1'b0, d};
                        o_state.phase   = cras_pkg::PH_2;
                        o_res0          = o_res1;
                        o_res0.address  = {8'd0, ptr};
                    end else if (i_state.mode_held == cras_pkg::AM_INDX &&
                                 i_state.phase == cras_pkg::PH_2) begin
                        o_state           = i_state;
                        o_state.high_byte = d;
                        o_state.phase     = cras_pkg::PH_3;
                        o_res0            = o_res1;
                        o_res0.address    = {d, i_state.low_sum[7:0]};
                    end
                end
                cras_pkg::AM_INDY: begin
                    if (i_state.phase == cras_pkg::PH_0) begin
                        o_state         = i_state;
                        o_state.low_sum = {1'b0, d};
                        o_state.phase   = cras_pkg::PH_1;
                        o_res0          = o_res1;
                        o_res0.address  = {8'd0, d};
                    end else if (i_state.phase == cras_pkg::PH_1) begin
                        o_state         = i_state;
                        o_state.low_sum = {1'b0, d};
                        o_state.phase   = cras_pkg::PH_2;
                        o_res0          = o_res1;
                        o_res0.address  = {8'd0, ptr};
                    end else if (i_state.phase == cras_pkg::PH_2) begin
                        o_state           = i_state;
                        o_state.high_byte = d;
                        o_state.low_sum   = sum;
                        o_state.phase     = cras_pkg::PH_3;
                        o_res0            = o_res1;
                        o_res0.address    = {d, sum[7:0]};
                    end else if (i_state.phase == cras_pkg::PH_3 && i_state.low_sum[8]) begin
                        o_state        = i_state;
                        o_state.phase  = cras_pkg::PH_4;
                        o_res0         = o_res1;
                        o_res0.address = {high_inc, i_state.low_sum[7:0]};
                    end
                end
                default: begin
                    // immediate: done with the returned byte
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### src/cpu_read_addressing_sequencer_core.sv
// Results are registered in the two-entry result buffer before they reach the output.
// Accepts one input per cycle while o_in_ready is high; an input that yields an idle
// cycle and a read places both results in the buffer.
// Reset (synchronous, active low) clears the sequence state and empties the buffer.
// Top level of the 6502 read-addressing bus sequencer; depends on cras_pkg, cras_step.
`timescale 1ns / 1ps
`default_nettype none

module cpu_read_addressing_sequencer_core (
    input  var logic           i_clk,
    input  var logic           i_rst_n,
    input  var logic           i_in_valid,
    output logic               o_in_ready,
    input  var cras_pkg::t_in  i_in,
    output logic               o_out_valid,
    input  var logic           i_out_ready,
    output cras_pkg::t_out     o_out
);

    cras_pkg::t_state r_state;
    cras_pkg::t_state n_state;
    cras_pkg::t_out   r_slot [2];
    cras_pkg::t_out   n_slot [2];
    logic [1:0]       r_cnt;
    logic [1:0]       n_cnt;

    cras_pkg::t_out   res0;
    cras_pkg::t_out   res1;
    logic [1:0]       nres;
    logic [1:0]       rem;
    logic [2:0]       total;
    logic             pop;
    logic             push;

    cras_step u_step (
        .i_state (r_state),
        .i_item  (i_in),
        .o_state (n_state),
        .o_res0  (res0),
        .o_res1  (res1),
        .o_nres  (nres)
    );

    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out       = r_slot[0];
    assign pop         = o_out_valid && i_out_ready;
    assign rem         = r_cnt - {1'b0, pop};
    assign total       = {1'b0, rem} + {1'b0, nres};
    assign o_in_ready  = (total <= 3'd2);
    assign push        = i_in_valid && o_in_ready;

    always_comb begin
        n_slot = r_slot;
        n_cnt  = rem;
        if (pop) begin
            n_slot[0] = r_slot[1];
        end
        if (push) begin
            if (rem == 2'd0) begin
                n_slot[0] = res0;
                n_slot[1] = res1;
            end else if (rem == 2'd1) begin
                n_slot[1] = res0;
            end
            n_cnt = total[1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
            r_cnt   <= 2'd0;
        end else begin
            if (push) begin
                r_state <= n_state;
            end
            r_cnt <= n_cnt;
        end
    end

    // result slots carry payload only
    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("result buffer count out of range");

    a_cnt_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ##1 $past(i_rst_n) |->
        ({1'b0, r_cnt} == $past({1'b0, r_cnt}) - {2'b0, $past(pop)} +
                          ($past(push) ? {1'b0, $past(nres)} : 3'd0)))
        else $error("result buffer count lost track of transfers");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && i_in.mode == cras_pkg::ITEM_START) |=> r_state.busy)
        else $error("start transfer did not begin a sequence");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out.kind == cras_pkg::KIND_DONE) == o_out.last))
        else $error("last flag does not match done result");

    a_idle_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && nres == 2'd2) |-> (res0.kind == cras_pkg::KIND_IDLE &&
                                    res1.kind == cras_pkg::KIND_READ))
        else $error("two-result step is not an idle cycle then a read");

endmodule

`default_nettype wire
